FILE: rtl/core/n2st_pkg.sv
// n2st_pkg: token codes, widths and ctrl/datapath interface types for the
// spoken-number token sequencer. No dependencies.
`default_nettype none
package n2st_pkg;
	localparam int VAL_W      = 32;
	localparam int TOK_W      = 6;
	localparam int BIN_W      = 30;
	localparam int DIGITS     = 9;
	localparam int BCD_W      = 4 * DIGITS;
	localparam int CONV_STEPS = BIN_W / 2;
	localparam int CNT_W      = $clog2(CONV_STEPS);
	localparam int MASK_W     = 18;

	localparam logic [TOK_W-1:0] TOK_ZERO       = 6'd0;
	localparam logic [TOK_W-1:0] TOK_TENS_BASE  = 6'd18;
	localparam logic [TOK_W-1:0] TOK_HUNDRED    = 6'd28;
	localparam logic [TOK_W-1:0] TOK_THOUSAND   = 6'd29;
	localparam logic [TOK_W-1:0] TOK_MILLION    = 6'd30;
	localparam logic [TOK_W-1:0] TOK_MINUS      = 6'd31;
	localparam logic [TOK_W-1:0] TOK_NEUTER_ONE = 6'd32;

	localparam logic [VAL_W-1:0] BILLION = 32'd1000000000;
	localparam logic [VAL_W-1:0] INT_MIN = 32'h8000_0000;

	typedef struct packed {
		logic load;
		logic shift;
		logic build;
		logic emit;
	} n2st_cmd_t;

	typedef struct packed {
		logic out_free;
		logic mask_last;
	} n2st_sts_t;
endpackage
`default_nettype wire

FILE: rtl/core/number_to_spoken_tokens_top.sv
// number_to_spoken_tokens_top: Swedish spoken-number token sequencer.
// Depends on n2st_pkg, n2st_ctrl, n2st_dp.
//
//  channel | handshake                | payload
//  in      | in_valid / in_ready      | value[31:0] signed
//  out     | out_valid / out_ready    | token[5:0], too_big, last
//  cfg     | cfg_we (no wait)         | cfg_wdata = neuter_mode
//
// Per number: accept, BCD conversion (2 bits per cycle), mask build, then
// one output beat per token, for N tokens (N = 1..15).
// Output register is refilled in the cycle its beat is taken; stalls on out
// only hold the emit state. Reset is asynchronous; neuter_mode resets to 0.
`default_nettype none
module number_to_spoken_tokens_top import n2st_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic             cfg_wdata,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [VAL_W-1:0] value,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [TOK_W-1:0]      token,
	output logic                  too_big,
	output logic                  last
);
	n2st_cmd_t cmd;
	n2st_sts_t sts;

	n2st_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	n2st_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.token     (token),
		.too_big   (too_big),
		.last      (last)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("accepted a beat but stayed ready");

	a_err_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && too_big |-> last && token == TOK_ZERO)
		else $error("error beat not final or nonzero token");

	a_token_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> token <= TOK_NEUTER_ONE)
		else $error("token code out of range");

	a_no_emit_while_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready && !(out_valid && !out_ready) |=> !(out_valid && !$past(out_valid)))
		else $error("beat produced while idle");
endmodule
`default_nettype wire

FILE: rtl/core/n2st_ctrl.sv
// n2st_ctrl: sequencing FSM (accept, binary-to-BCD steps, mask build, emit).
// Depends on n2st_pkg.
`default_nettype none
module n2st_ctrl import n2st_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire n2st_sts_t sts,
	output n2st_cmd_t      cmd
);
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_MASK,
		ST_EMIT
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign cmd.load  = in_valid && in_ready;
	assign cmd.shift = (state_q == ST_CONV);
	assign cmd.build = (state_q == ST_MASK);
	assign cmd.emit  = (state_q == ST_EMIT) && sts.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (cmd.load) begin
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(CONV_STEPS - 1)) begin
						state_q <= ST_MASK;
					end
				end
				ST_MASK: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (cmd.emit && sts.mask_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

FILE: rtl/core/n2st_dp.sv
// n2st_dp: magnitude/flags, 2-bit-per-cycle binary-to-BCD converter, token
// mask, token select and output register. Depends on n2st_pkg.
`default_nettype none
module n2st_dp import n2st_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire n2st_cmd_t         cmd,
	output n2st_sts_t              sts,
	input  wire logic              cfg_we,
	input  wire logic              cfg_wdata,
	input  wire logic [VAL_W-1:0]  value,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [TOK_W-1:0]       token,
	output logic                   too_big,
	output logic                   last
);
	typedef logic [4:0][TOK_W-1:0] grp_tok_t;

	logic              neuter_q;
	logic              neg_q, err_q, imin_q, zero_q;
	logic [BIN_W-1:0]  bin_q;
	logic [BCD_W-1:0]  bcd_q;
	logic [MASK_W-1:0] mask_q;
	logic              out_valid_q;
	logic [TOK_W-1:0]  token_q;
	logic              too_big_q, last_q;

	logic [VAL_W-1:0]  mag;
	logic [MASK_W-1:0] mask_new, low_bit, mask_rest;
	logic [MASK_W-1:0][TOK_W-1:0] tok_arr;
	logic [TOK_W-1:0]  tok_sel;
	grp_tok_t          g0_tok, g1_tok, g2_tok;

	function automatic logic [BCD_W-1:0] dd_step(input logic [BCD_W-1:0] b,
	                                             input logic bit_in);
		logic [BCD_W-1:0] a;
		a = b;
		for (int i = 0; i < DIGITS; i++) begin
			if (a[4*i +: 4] >= 4'd5) begin
				a[4*i +: 4] = a[4*i +: 4] + 4'd3;
			end
		end
		return {a[BCD_W-2:0], bit_in};
	endfunction

	function automatic logic [TOK_W-1:0] small_tok(input logic [4:0] v, input logic neu);
		return (v == 5'd1 && neu) ? TOK_NEUTER_ONE : {1'b0, v};
	endfunction

	// order: hundreds digit, hundred, tens or teen, unit, group name
	function automatic grp_tok_t grp_tok(input logic [3:0] h, input logic [3:0] t,
	                                     input logic [3:0] u, input logic [TOK_W-1:0] nm,
	                                     input logic neu);
		grp_tok_t r;
		logic [4:0] teen;
		teen    = t[0] ? (5'd10 + {1'b0, u}) : {1'b0, u};
		r[0]    = {2'b00, h};
		r[1]    = TOK_HUNDRED;
		r[2]    = (t >= 4'd2) ? (TOK_TENS_BASE + {2'b00, t}) : small_tok(teen, neu);
		r[3]    = small_tok({1'b0, u}, neu);
		r[4]    = nm;
		return r;
	endfunction

	function automatic logic [4:0] grp_mask(input logic [3:0] h, input logic [3:0] t,
	                                        input logic [3:0] u, input logic named);
		logic [4:0] m;
		m[0] = (h != 4'd0);
		m[1] = (h != 4'd0);
		m[2] = (t != 4'd0) || (u != 4'd0);
		m[3] = (t >= 4'd2) && (u != 4'd0);
		m[4] = named && ((h != 4'd0) || (t != 4'd0) || (u != 4'd0));
		return m;
	endfunction

	assign mag = value[VAL_W-1] ? (~value + 1'b1) : value;

	always_comb begin
		logic en;
		en = !err_q && !imin_q && !zero_q;
		mask_new[0] = neg_q;
		mask_new[1] = err_q;
		mask_new[2] = zero_q;
		mask_new[7:3]   = en ? grp_mask(bcd_q[35:32], bcd_q[31:28], bcd_q[27:24], 1'b1) : '0;
		mask_new[12:8]  = en ? grp_mask(bcd_q[23:20], bcd_q[19:16], bcd_q[15:12], 1'b1) : '0;
		mask_new[17:13] = en ? grp_mask(bcd_q[11:8],  bcd_q[7:4],   bcd_q[3:0],   1'b0) : '0;
	end

	assign g0_tok = grp_tok(bcd_q[35:32], bcd_q[31:28], bcd_q[27:24], TOK_MILLION, neuter_q);
	assign g1_tok = grp_tok(bcd_q[23:20], bcd_q[19:16], bcd_q[15:12], TOK_THOUSAND, neuter_q);
	assign g2_tok = grp_tok(bcd_q[11:8],  bcd_q[7:4],   bcd_q[3:0],   TOK_ZERO, neuter_q);

	always_comb begin
		tok_arr[0] = TOK_MINUS;
		tok_arr[1] = TOK_ZERO;
		tok_arr[2] = TOK_ZERO;
		for (int i = 0; i < 5; i++) begin
			tok_arr[3 + i]  = g0_tok[i];
			tok_arr[8 + i]  = g1_tok[i];
			tok_arr[13 + i] = g2_tok[i];
		end
	end

	assign low_bit   = mask_q & (~mask_q + 1'b1);
	assign mask_rest = mask_q & ~low_bit;

	always_comb begin
		tok_sel = '0;
		for (int i = 0; i < MASK_W; i++) begin
			if (low_bit[i]) begin
				tok_sel = tok_sel | tok_arr[i];
			end
		end
	end

	assign sts.out_free  = !out_valid_q || out_ready;
	assign sts.mask_last = (mask_rest == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			neuter_q    <= 1'b0;
			out_valid_q <= 1'b0;
			mask_q      <= '0;
		end else begin
			if (cfg_we) begin
				neuter_q <= cfg_wdata;
			end
			if (cmd.build) begin
				mask_q <= mask_new;
			end else if (cmd.emit) begin
				mask_q <= mask_rest;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			neg_q  <= value[VAL_W-1];
			imin_q <= (value == INT_MIN);
			zero_q <= (value == '0);
			err_q  <= (value != INT_MIN) && (mag >= BILLION);
			bin_q  <= mag[BIN_W-1:0];
			bcd_q  <= '0;
		end else if (cmd.shift) begin
			bin_q <= {bin_q[BIN_W-3:0], 2'b00};
			bcd_q <= dd_step(dd_step(bcd_q, bin_q[BIN_W-1]), bin_q[BIN_W-2]);
		end
		if (cmd.emit) begin
			token_q   <= tok_sel;
			too_big_q <= low_bit[1];
			last_q    <= (mask_rest == '0);
		end
	end

	assign out_valid = out_valid_q;
	assign token     = token_q;
	assign too_big   = too_big_q;
	assign last      = last_q;
endmodule
`default_nettype wire
